>>> src/wheel_power_limiter_top_macros.svh
// Assertion macros of the wheel power limiter checker
`ifndef WHEEL_POWER_LIMITER_TOP_MACROS_SVH
`define WHEEL_POWER_LIMITER_TOP_MACROS_SVH

// check outside reset
`define WPL_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("wheel power limiter check failed");

// check that also covers the reset cycles
`define WPL_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("wheel power limiter reset check failed");

`endif

>>> src/wpl_pkg.sv
// Shared types and constants of the wheel power limiter
package wpl_pkg;

  localparam int FIELD_WHEELS  = 2;
  localparam int WHEELS_DEFAULT = 2;
  localparam int QUEUE_DEPTH   = 4;
  localparam int DIV_BITS      = 20;

  localparam logic [19:0] RECIP_TAB [FIELD_WHEELS] = '{20'd646120, 20'd699051};
  localparam logic [21:0] C_TQ        = 22'd2195604;
  localparam logic [25:0] C_K2        = 26'd40898314;
  localparam logic [17:0] C_A         = 18'd135240;
  localparam logic [7:0]  CONST_POWER = 8'd128;
  localparam logic [10:0] CAP_MARGIN  = 11'd30;
  localparam logic [17:0] CAP_FLOOR_Q = 18'd11520;
  localparam logic [23:0] TOTAL_MAX   = 24'hFFFFFF;

  typedef struct packed {
    logic [FIELD_WHEELS-1:0][19:0] tq;
    logic [FIELD_WHEELS-1:0][19:0] mag;
    logic [23:0]                   total;
    logic [20:0]                   budget;
  } wpl_item_t;

endpackage

>>> src/wpl_if.sv
// Request and result channel interfaces
interface wpl_in_if;
  logic               valid;
  logic               ready;
  logic signed [19:0] torque_left;
  logic signed [19:0] torque_right;
  logic signed [15:0] speed_left;
  logic signed [15:0] speed_right;
  logic [9:0]         referee_limit;
  logic               cap_online;
  logic [17:0]        cap_limit;
  logic signed [18:0] buffer_correction;

  modport source(output valid, torque_left, torque_right, speed_left, speed_right,
                 referee_limit, cap_online, cap_limit, buffer_correction, input ready);
  modport sink(input valid, torque_left, torque_right, speed_left, speed_right,
               referee_limit, cap_online, cap_limit, buffer_correction, output ready);
endinterface

interface wpl_out_if;
  logic               valid;
  logic               ready;
  logic signed [19:0] out_torque_left;
  logic signed [19:0] out_torque_right;
  logic signed [15:0] current_left;
  logic signed [15:0] current_right;
  logic               limited;
  logic [23:0]        power_estimate;

  modport source(output valid, out_torque_left, out_torque_right, current_left,
                 current_right, limited, power_estimate, input ready);
  modport sink(input valid, out_torque_left, out_torque_right, current_left,
               current_right, limited, power_estimate, output ready);
endinterface

>>> src/wpl_front.sv
// Front pipeline: budget selection and power estimate
module wpl_front #(
  parameter int WHEELS = wpl_pkg::WHEELS_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  wpl_in_if.sink            tick,
  output wpl_pkg::wpl_item_t item,
  output logic              item_valid,
  input  logic              item_ready
);
  import wpl_pkg::*;

  logic [5:1] vld;
  logic       en;

  logic [FIELD_WHEELS-1:0][19:0] tq_in, tq1, tq2, tq3, tq4, tq5;
  logic [FIELD_WHEELS-1:0][19:0] mag_next, mag1, mag2, mag3, mag4, mag5;
  logic [FIELD_WHEELS-1:0][15:0] spm_next, spm1, spm2;
  logic [FIELD_WHEELS-1:0][15:0] sp_in;
  logic [20:0] budget_next, bud1, bud2, bud3, bud4, bud5;
  logic [18:0] ceil_v;

  logic [FIELD_WHEELS-1:0][39:0] iq_prod;
  logic [FIELD_WHEELS-1:0][22:0] iq2;
  logic [FIELD_WHEELS-1:0][31:0] sp2_2;
  logic [FIELD_WHEELS-1:0][38:0] iqsp3;
  logic [FIELD_WHEELS-1:0][45:0] iqsq3;
  logic [FIELD_WHEELS-1:0][57:0] k2_prod;
  logic [FIELD_WHEELS-1:0][16:0] k2_3, k2_4;
  logic [FIELD_WHEELS-1:0][60:0] t1_prod;
  logic [FIELD_WHEELS-1:0][63:0] t3_prod;
  logic [FIELD_WHEELS-1:0][20:0] t1_4;
  logic [FIELD_WHEELS-1:0][15:0] t3_4;
  logic [24:0] sum_next;
  logic [23:0] total5;

  assign en         = !(vld[5] && !item_ready);
  assign tick.ready = en;
  assign item_valid = vld[5];

  always_comb begin
    tq_in[0] = tick.torque_left;
    tq_in[1] = tick.torque_right;
    sp_in[0] = tick.speed_left;
    sp_in[1] = tick.speed_right;
    for (int w = 0; w < FIELD_WHEELS; w++) begin
      mag_next[w] = tq_in[w][19] ? 20'(-tq_in[w]) : tq_in[w];
      spm_next[w] = sp_in[w][15] ? 16'(-sp_in[w]) : sp_in[w];
    end
    ceil_v = {({1'b0, tick.referee_limit} + CAP_MARGIN), 8'b0};
    if (tick.cap_online) begin
      if ({1'b0, tick.cap_limit} > ceil_v) begin
        budget_next = {2'b0, ceil_v};
      end else if (tick.cap_limit < CAP_FLOOR_Q) begin
        budget_next = {3'b0, CAP_FLOOR_Q};
      end else begin
        budget_next = {3'b0, tick.cap_limit};
      end
    end else begin
      budget_next = {3'b0, tick.referee_limit, 8'b0}
                  - {{2{tick.buffer_correction[18]}}, tick.buffer_correction};
    end
  end

  always_comb begin
    sum_next = '0;
    for (int w = 0; w < FIELD_WHEELS; w++) begin
      iq_prod[w] = 40'(mag1[w]) * 40'(RECIP_TAB[w]);
      k2_prod[w] = 58'(sp2_2[w]) * 58'(C_K2);
      t1_prod[w] = 61'(iqsp3[w]) * 61'(C_TQ);
      t3_prod[w] = 64'(iqsq3[w]) * 64'(C_A);
      if (w < WHEELS) begin
        sum_next = sum_next + 25'(t1_4[w]) + 25'(k2_4[w]) + 25'(t3_4[w])
                 + 25'(CONST_POWER);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[4:1], tick.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tq1 <= tq_in;  mag1 <= mag_next; spm1 <= spm_next; bud1 <= budget_next;
      tq2 <= tq1;    mag2 <= mag1;     spm2 <= spm1;     bud2 <= bud1;
      tq3 <= tq2;    mag3 <= mag2;     bud3 <= bud2;
      tq4 <= tq3;    mag4 <= mag3;     bud4 <= bud3;
      tq5 <= tq4;    mag5 <= mag4;     bud5 <= bud4;
      for (int w = 0; w < FIELD_WHEELS; w++) begin
        iq2[w]   <= iq_prod[w][38:16];
        sp2_2[w] <= 32'(spm1[w]) * 32'(spm1[w]);
        iqsp3[w] <= 39'(iq2[w]) * 39'(spm2[w]);
        iqsq3[w] <= 46'(iq2[w]) * 46'(iq2[w]);
        k2_3[w]  <= k2_prod[w][56:40];
        t1_4[w]  <= t1_prod[w][60:40];
        t3_4[w]  <= t3_prod[w][63:48];
        k2_4[w]  <= k2_3[w];
      end
      total5 <= (sum_next > {1'b0, TOTAL_MAX}) ? TOTAL_MAX : sum_next[23:0];
    end
  end

  always_comb begin
    item.tq     = tq5;
    item.mag    = mag5;
    item.total  = total5;
    item.budget = bud5;
  end

endmodule

>>> src/wpl_queue.sv
// Short request queue between front and back
module wpl_queue #(
  parameter int DEPTH = wpl_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  wpl_pkg::wpl_item_t push_item,
  input  logic               push_valid,
  output logic               push_ready,
  output wpl_pkg::wpl_item_t pop_item,
  output logic               pop_valid,
  input  logic               pop_ready
);
  import wpl_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  wpl_item_t        mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push, pop;

  assign push_ready = count != CNT_W'(DEPTH);
  assign pop_valid  = count != '0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_item   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

endmodule

>>> src/wpl_back.sv
// Back pipeline: limit decision, torque scaling divider, current commands
module wpl_back #(
  parameter int WHEELS = wpl_pkg::WHEELS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  wpl_pkg::wpl_item_t item,
  input  logic               item_valid,
  output logic               item_ready,
  wpl_out_if.source          result
);
  import wpl_pkg::*;

  logic [DIV_BITS:0] vld;
  logic              o_vld;
  logic              en;

  logic [FIELD_WHEELS-1:0][19:0] tq   [DIV_BITS+1];
  logic [FIELD_WHEELS-1:0][24:0] rem  [DIV_BITS+1];
  logic [FIELD_WHEELS-1:0][19:0] nl   [DIV_BITS+1];
  logic [FIELD_WHEELS-1:0][19:0] quo  [DIV_BITS+1];
  logic [FIELD_WHEELS-1:0]       apply[DIV_BITS+1];
  logic                          lim  [DIV_BITS+1];
  logic [23:0]                   tot  [DIV_BITS+1];

  logic                          lim_next, scale_next;
  logic [FIELD_WHEELS-1:0][39:0] num_next;
  logic [FIELD_WHEELS-1:0][24:0] shf    [DIV_BITS+1];
  logic [FIELD_WHEELS-1:0]       ge     [DIV_BITS+1];
  logic [FIELD_WHEELS-1:0][39:0] cur_prod;
  logic [FIELD_WHEELS-1:0][15:0] cmag;
  logic [FIELD_WHEELS-1:0][19:0] otq_next;
  logic [FIELD_WHEELS-1:0][15:0] cur_next;
  logic [FIELD_WHEELS-1:0][19:0] o_tq;
  logic [FIELD_WHEELS-1:0][15:0] o_cur;
  logic                          o_lim;
  logic [23:0]                   o_tot;

  assign en         = !o_vld || result.ready;
  assign item_ready = en;

  always_comb begin
    lim_next   = $signed({1'b0, item.total}) > $signed({{4{item.budget[20]}}, item.budget});
    scale_next = lim_next && !item.budget[20] && (item.budget != '0) && (item.total != '0);
    for (int w = 0; w < FIELD_WHEELS; w++) begin
      num_next[w] = scale_next ? 40'(item.mag[w]) * 40'(item.budget[19:0]) : '0;
    end
    for (int s = 1; s <= DIV_BITS; s++) begin
      for (int w = 0; w < FIELD_WHEELS; w++) begin
        shf[s][w] = {rem[s-1][w][23:0], nl[s-1][w][19]};
        ge[s][w]  = shf[s][w] >= {1'b0, tot[s-1]};
      end
    end
    shf[0] = '0;
    ge[0]  = '0;
    for (int w = 0; w < FIELD_WHEELS; w++) begin
      cur_prod[w] = 40'(quo[DIV_BITS][w]) * 40'(RECIP_TAB[w]);
      cmag[w]     = cur_prod[w][39:24];
      if (apply[DIV_BITS][w]) begin
        if (tq[DIV_BITS][w][19]) begin
          otq_next[w] = 20'(-quo[DIV_BITS][w]);
          cur_next[w] = (cmag[w] > 16'd32768) ? 16'h8000 : 16'(-cmag[w]);
        end else begin
          otq_next[w] = quo[DIV_BITS][w];
          cur_next[w] = (cmag[w] > 16'd32767) ? 16'h7FFF : cmag[w];
        end
      end else begin
        otq_next[w] = tq[DIV_BITS][w];
        cur_next[w] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld   <= '0;
      o_vld <= 1'b0;
    end else if (en) begin
      vld   <= {vld[DIV_BITS-1:0], item_valid};
      o_vld <= vld[DIV_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tq[0]  <= item.tq;
      lim[0] <= lim_next;
      tot[0] <= item.total;
      for (int w = 0; w < FIELD_WHEELS; w++) begin
        apply[0][w] <= lim_next && (w < WHEELS);
        rem[0][w]   <= {5'b0, num_next[w][39:20]};
        nl[0][w]    <= num_next[w][19:0];
        quo[0][w]   <= '0;
      end
      for (int s = 1; s <= DIV_BITS; s++) begin
        tq[s]    <= tq[s-1];
        lim[s]   <= lim[s-1];
        tot[s]   <= tot[s-1];
        apply[s] <= apply[s-1];
        for (int w = 0; w < FIELD_WHEELS; w++) begin
          rem[s][w] <= ge[s][w] ? shf[s][w] - {1'b0, tot[s-1]} : shf[s][w];
          nl[s][w]  <= {nl[s-1][w][18:0], 1'b0};
          quo[s][w] <= {quo[s-1][w][18:0], ge[s][w]};
        end
      end
      o_tq  <= otq_next;
      o_cur <= cur_next;
      o_lim <= lim[DIV_BITS];
      o_tot <= tot[DIV_BITS];
    end
  end

  assign result.valid            = o_vld;
  assign result.out_torque_left  = o_tq[0];
  assign result.out_torque_right = o_tq[1];
  assign result.current_left     = o_cur[0];
  assign result.current_right    = o_cur[1];
  assign result.limited          = o_lim;
  assign result.power_estimate   = o_tot;

endmodule

>>> src/wheel_power_limiter_top.sv
// Top level of the wheel power limiter
//  channel  | dir | handshake     | payload
//  tick     | in  | valid / ready | torques, speeds, limits, correction
//  result   | out | valid / ready | scaled torques, currents, limited, estimate
// One request per cycle sustained while result.ready stays high; a result passes
// through 5 estimate stages, one queue slot, the decision stage, 20 divider stages
// and the output register.
// The divider pipeline computes one quotient bit per stage.
// rst is synchronous and clears all valid bits and the queue.
// A stalled result holds the back pipeline; the queue holds four requests, and
// tick.ready drops once it is full and the last estimate stage holds a request.
module wheel_power_limiter_top #(
  parameter int WHEELS = wpl_pkg::WHEELS_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  wpl_in_if.sink    tick,
  wpl_out_if.source result
);
  import wpl_pkg::*;

  wpl_item_t front_item, back_item;
  logic      front_valid, front_ready, back_valid, back_ready;

  wpl_front #(.WHEELS(WHEELS)) u_front (
    .clk(clk), .rst(rst), .tick(tick),
    .item(front_item), .item_valid(front_valid), .item_ready(front_ready)
  );

  wpl_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk(clk), .rst(rst),
    .push_item(front_item), .push_valid(front_valid), .push_ready(front_ready),
    .pop_item(back_item), .pop_valid(back_valid), .pop_ready(back_ready)
  );

  wpl_back #(.WHEELS(WHEELS)) u_back (
    .clk(clk), .rst(rst),
    .item(back_item), .item_valid(back_valid), .item_ready(back_ready),
    .result(result)
  );

endmodule

>>> src/wpl_checker.sv
// Port-level checker for the wheel power limiter and its bind
`include "wheel_power_limiter_top_macros.svh"

module wpl_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic        limited,
  input logic [15:0] current_left,
  input logic [15:0] current_right,
  input logic [23:0] power_estimate
);

  `WPL_ASSERT(a_result_held, out_valid && !out_ready |=> out_valid)
  `WPL_ASSERT(a_unlimited_zero_current, out_valid && !limited |-> (current_left | current_right) == 16'd0)
  `WPL_ASSERT(a_total_floor, out_valid |-> power_estimate >= 24'd128)
  `WPL_ASSERT_RST(a_reset_clears, rst |=> !out_valid)

endmodule

bind wheel_power_limiter_top wpl_checker u_checker (
  .clk(clk), .rst(rst),
  .out_valid(result.valid), .out_ready(result.ready),
  .limited(result.limited),
  .current_left(result.current_left), .current_right(result.current_right),
  .power_estimate(result.power_estimate)
);

>>> tb/wpl_tb_if.sv
`timescale 1ns / 1ps
// Result record type shared by the testbench
package wpl_tb_types_pkg;
  typedef struct packed {
    logic signed [19:0] tq_l;
    logic signed [19:0] tq_r;
    logic signed [15:0] cur_l;
    logic signed [15:0] cur_r;
    logic               lim;
    logic [23:0]        total;
  } wpl_result_t;
endpackage

>>> tb/wheel_power_limiter_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of the wheel power limiter top level
module wheel_power_limiter_top_tb;
  import wpl_tb_types_pkg::*;

  class power_scoreboard;
    wpl_result_t pending[$];
    int errors = 0;

    function longint unsigned wheel_power(longint tq, longint rpm,
                                          longint unsigned recip);
      longint unsigned iq, sp, p;
      iq = ((tq < 0 ? -tq : tq) * recip) >> 16;
      sp = rpm < 0 ? -rpm : rpm;
      p = (iq * sp * wpl_pkg::C_TQ) >> 40;
      p += (sp * sp * wpl_pkg::C_K2) >> 40;
      p += (iq * iq * wpl_pkg::C_A) >> 48;
      return p + 128;
    endfunction

    function void note_request(logic signed [19:0] tl, logic signed [19:0] tr,
                               logic signed [15:0] sl, logic signed [15:0] sr,
                               logic [9:0] refl, logic online, logic [17:0] cap,
                               logic signed [18:0] corr);
      longint budget, ceil_v;
      longint tq[2], sp[2], res_t[2], cur[2];
      longint unsigned total, m, c, recip;
      logic lim;
      wpl_result_t r;
      tq[0] = tl; tq[1] = tr; sp[0] = sl; sp[1] = sr;
      if (online) begin
        ceil_v = (longint'(refl) + 30) * 256;
        if (longint'(cap) > ceil_v) budget = ceil_v;
        else if (cap < 45 * 256) budget = longint'(45 * 256);
        else budget = longint'(cap);
      end else begin
        budget = longint'(refl) * 256 - longint'(corr);
      end
      total = 0;
      for (int i = 0; i < 2; i++) begin
        total += wheel_power(tq[i], sp[i], wpl_pkg::RECIP_TAB[i]);
        if (total > 24'hFFFFFF) total = 24'hFFFFFF;
      end
      lim = longint'(total) > budget;
      for (int i = 0; i < 2; i++) begin
        res_t[i] = tq[i];
        cur[i] = 0;
        if (lim) begin
          recip = wpl_pkg::RECIP_TAB[i];
          m = 0;
          if (budget > 0 && total > 0)
            m = ((tq[i] < 0 ? -tq[i] : tq[i]) * longint'(budget)) / total;
          c = (m * recip) >> 24;
          if (tq[i] < 0) begin
            res_t[i] = -longint'(m);
            cur[i] = c > 32768 ? -32768 : -longint'(c);
          end else begin
            res_t[i] = m;
            cur[i] = c > 32767 ? 32767 : c;
          end
        end
      end
      r.tq_l = 20'(res_t[0]); r.tq_r = 20'(res_t[1]);
      r.cur_l = 16'(cur[0]); r.cur_r = 16'(cur[1]);
      r.lim = lim; r.total = total[23:0];
      pending.push_back(r);
    endfunction

    function void check_result(wpl_result_t act);
      wpl_result_t exp_r;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $realtime, act);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (exp_r !== act) begin
        $display("%0t: mismatch expected tq %0d/%0d cur %0d/%0d lim %0b total %0d",
                 $realtime, exp_r.tq_l, exp_r.tq_r, exp_r.cur_l, exp_r.cur_r,
                 exp_r.lim, exp_r.total);
        $display("%0t:          actual   tq %0d/%0d cur %0d/%0d lim %0b total %0d",
                 $realtime, act.tq_l, act.tq_r, act.cur_l, act.cur_r, act.lim,
                 act.total);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  wpl_in_if  tick();
  wpl_out_if result();
  power_scoreboard sb = new();
  int send_idle = 0;
  int recv_stall = 0;
  int idle_cnt = 0;

  wheel_power_limiter_top i_dut (.clk(clk), .rst(rst), .tick(tick), .result(result));

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    tick.valid = 0;
    tick.torque_left = 0; tick.torque_right = 0;
    tick.speed_left = 0; tick.speed_right = 0;
    tick.referee_limit = 0; tick.cap_online = 0;
    tick.cap_limit = 0; tick.buffer_correction = 0;
    result.ready = 0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      result.ready <= ($urandom_range(99) >= recv_stall);
      if (result.valid && result.ready)
        sb.check_result({result.out_torque_left, result.out_torque_right,
                         result.current_left, result.current_right,
                         result.limited, result.power_estimate});
      if ((tick.valid && tick.ready) || (result.valid && result.ready)) idle_cnt <= 0;
      else idle_cnt <= idle_cnt + 1;
      if (idle_cnt > 20000) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  task automatic send_tick(logic signed [19:0] tl, logic signed [19:0] tr,
                           logic signed [15:0] sl, logic signed [15:0] sr,
                           logic [9:0] refl, logic online, logic [17:0] cap,
                           logic signed [18:0] corr);
    while ($urandom_range(99) < send_idle) begin
      tick.valid <= 0;
      @(posedge clk);
    end
    tick.valid <= 1;
    tick.torque_left <= tl; tick.torque_right <= tr;
    tick.speed_left <= sl; tick.speed_right <= sr;
    tick.referee_limit <= refl; tick.cap_online <= online;
    tick.cap_limit <= cap; tick.buffer_correction <= corr;
    @(posedge clk);
    while (!tick.ready) @(posedge clk);
    sb.note_request(tl, tr, sl, sr, refl, online, cap, corr);
  endtask

  task automatic send_random();
    logic signed [19:0] tl, tr;
    logic signed [15:0] sl, sr;
    case ($urandom_range(3))
      0: begin
        tl = 20'($urandom); tr = 20'($urandom); sl = 16'($urandom); sr = 16'($urandom);
      end
      default: begin
        tl = 20'($signed(20'($urandom_range(40000))) * ($urandom_range(1) ? 1 : -1));
        tr = 20'($signed(20'($urandom_range(40000))) * ($urandom_range(1) ? 1 : -1));
        sl = 16'($signed(16'($urandom_range(9000))) * ($urandom_range(1) ? 1 : -1));
        sr = 16'($signed(16'($urandom_range(9000))) * ($urandom_range(1) ? 1 : -1));
      end
    endcase
    send_tick(tl, tr, sl, sr,
              $urandom_range(3) == 0 ? 10'($urandom) : 10'($urandom_range(20, 150)),
              1'($urandom_range(1)),
              $urandom_range(1) ? 18'($urandom) : 18'($urandom_range(5000, 50000)),
              $urandom_range(3) == 0 ? 19'($urandom) : 19'($signed($urandom_range(8000)) - 4000));
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    send_tick(20'sd0, 20'sd0, 16'sd0, 16'sd0, 10'd0, 1'b0, 18'd0, 19'sd0);
    send_tick(20'sh7FFFF, 20'sh80000, 16'sh7FFF, 16'sh8000, 10'd1023, 1'b0, 18'd0, 19'sh3FFFF);
    send_tick(20'sh80000, 20'sh7FFFF, 16'sh8000, 16'sh7FFF, 10'd0, 1'b0, 18'd0, 19'sh40000);
    send_tick(20'sh80000, 20'sh80000, 16'sh8000, 16'sh8000, 10'd1023, 1'b1, 18'h3FFFF, 19'sd0);
    send_tick(20'sd20000, -20'sd20000, 16'sd3000, -16'sd3000, 10'd50, 1'b1, 18'd100, 19'sd0);
    send_tick(20'sd20000, -20'sd20000, 16'sd3000, -16'sd3000, 10'd50, 1'b1, 18'd15000, 19'sd0);
    send_tick(20'sd20000, 20'sd30000, 16'sd3000, 16'sd4000, 10'd5, 1'b1, 18'd20000, 19'sd0);
    send_tick(20'sd20000, 20'sd30000, 16'sd3000, 16'sd4000, 10'd10, 1'b0, 18'd0, 19'sd5000);
    send_tick(-20'sd30000, 20'sd30000, 16'sd100, 16'sd200, 10'd80, 1'b0, 18'd0, 19'sd0);
    send_tick(20'sd1000, 20'sd1000, 16'sd10, 16'sd10, 10'd80, 1'b0, 18'd0, -19'sd100);
    send_tick(20'sd0, 20'sd0, 16'sd0, 16'sd0, 10'd0, 1'b0, 18'd0, 19'sd1);
    send_tick(20'sd1, -20'sd1, 16'sd1, -16'sd1, 10'd0, 1'b1, 18'd11520, 19'sh2AAAA);
    for (int ph = 0; ph < 4; ph++) begin
      send_idle = (ph == 1 || ph == 3) ? (ph == 1 ? 80 : 31) : 0;
      recv_stall = (ph == 2 || ph == 3) ? (ph == 2 ? 80 : 31) : 0;
      for (int n = 0; n < 175; n++) send_random();
    end
    tick.valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end
endmodule

>>> wheel_power_limiter_top.f
+incdir+src
src/wpl_pkg.sv
src/wpl_if.sv
src/wpl_front.sv
src/wpl_queue.sv
src/wpl_back.sv
src/wheel_power_limiter_top.sv
src/wpl_checker.sv
tb/wpl_tb_if.sv
tb/wheel_power_limiter_top_tb.sv
